### src/assert_macros.svh
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PSDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PSDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/psdf_pkg.sv
// shared types and constants of the point set difference filter
package psdf_pkg;

	localparam int TableDepth = 1024;
	localparam int AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
	localparam int CountW     = $clog2(TableDepth + 1);
	localparam int CoordW     = 32;
	localparam int PointW     = 3 * CoordW;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		STATUS_STORED  = 3'd0,
		STATUS_FULL    = 3'd1,
		STATUS_KEPT    = 3'd2,
		STATUS_REMOVED = 3'd3,
		STATUS_CLEARED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic rd_en;
		logic emit;
	} psdf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query;
		logic table_empty;
		logic scan_last;
		logic out_free;
	} psdf_stat_t;

endpackage

### src/psdf_ram.sv
// generic single write port ram with registered read
module psdf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                           rdata
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/psdf_ctrl.sv
// controller state machine of the point set difference filter
module psdf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  psdf_pkg::psdf_stat_t   stat,
	output psdf_pkg::psdf_cmd_t    cmd
);
	import psdf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (stat.query && !stat.table_empty) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: state_nxt = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd.take  = 1'b0;
		cmd.rd_en = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_SCAN:  cmd.rd_en = 1'b1;
			ST_FLUSH: ;
			ST_DONE:  cmd.emit = stat.out_free;
			default: ;
		endcase
	end

endmodule

### src/psdf_dp.sv
// datapath: reference table, scan compare and result register
module psdf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psdf_pkg::psdf_cmd_t           cmd,
	output psdf_pkg::psdf_stat_t          stat,
	input  logic [1:0]                    req_type,
	input  logic [psdf_pkg::CoordW-1:0]   pos_x,
	input  logic [psdf_pkg::CoordW-1:0]   pos_y,
	input  logic [psdf_pkg::CoordW-1:0]   pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [psdf_pkg::CoordW-1:0]   out_x,
	output logic [psdf_pkg::CoordW-1:0]   out_y,
	output logic [psdf_pkg::CoordW-1:0]   out_z
);
	import psdf_pkg::*;

	logic [CountW-1:0] count_q;
	logic [AddrW-1:0]  rd_addr_q;
	logic              cmp_vld_s1;
	logic [PointW-1:0] item_q;
	status_t           status_q;
	logic [PointW-1:0] rd_data;
	logic              table_full;
	logic              ram_we;
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [PointW-1:0] out_point_q;

	assign table_full = (count_q == CountW'(TableDepth));
	assign ram_we     = cmd.take && (req_t'(req_type) == REQ_LOAD) && !table_full;

	psdf_ram #(
		.Width(PointW),
		.Depth(TableDepth)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AddrW-1:0]),
		.wdata({pos_x, pos_y, pos_z}),
		.re   (cmd.rd_en),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	// table fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take) begin
			if (ram_we) begin
				count_q <= count_q + CountW'(1);
			end else if (req_t'(req_type) == REQ_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// scan address and compare stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q  <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.rd_en;
			if (cmd.take) begin
				rd_addr_q <= '0;
			end else if (cmd.rd_en) begin
				rd_addr_q <= rd_addr_q + AddrW'(1);
			end
		end
	end

	// held item and its status
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= {pos_x, pos_y, pos_z};
			case (req_t'(req_type))
				REQ_LOAD:  status_q <= table_full ? STATUS_FULL : STATUS_STORED;
				REQ_CLEAR: status_q <= STATUS_CLEARED;
				default:   status_q <= STATUS_KEPT;
			endcase
		end else if (cmp_vld_s1 && (rd_data == item_q)) begin
			status_q <= STATUS_REMOVED;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_point_q  <= item_q;
		end
	end

	assign stat.query       = (req_t'(req_type) != REQ_LOAD) && (req_t'(req_type) != REQ_CLEAR);
	assign stat.table_empty = (count_q == '0);
	assign stat.scan_last   = ({1'b0, rd_addr_q} == (count_q - CountW'(1)));
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_x     = out_point_q[PointW-1 -: CoordW];
	assign out_y     = out_point_q[CoordW +: CoordW];
	assign out_z     = out_point_q[CoordW-1:0];

endmodule

### src/point_set_difference_filter.sv
// point set difference filter: top level
// usage
//  - request channel: in_valid / in_ready with req_type, pos_x, pos_y, pos_z
//    (load stores a reference point, query checks a point, clear empties the table)
//  - result channel: out_valid / out_ready with status, out_x, out_y, out_z;
//    every request gives exactly one result, the point is echoed unchanged
//  - the table holds up to 1024 points in one ram with a registered read port
//  - one request is in flight at a time; in_ready is high only when idle
//  - load and clear: the controller goes straight to the done state, which loads
//    the result register once it is free and returns to idle for the next request
//  - query: scans stored entries one per cycle through the ram read port,
//    then a flush state lets the last compare finish before the done state,
//    which loads the result register once it is free
//  - a query with an empty table finishes like a load
//  - a result register sits on the output, so the next request is taken
//    while the previous result still waits for out_ready
//  - if the receiver stalls with a result pending, the finished next result
//    waits in the datapath and no further request is taken
//  - reset empties the table (fill count to zero) and drops any pending result
//  - request type three behaves as a query
module point_set_difference_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [psdf_pkg::CoordW-1:0] pos_x,
	input  logic [psdf_pkg::CoordW-1:0] pos_y,
	input  logic [psdf_pkg::CoordW-1:0] pos_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [psdf_pkg::CoordW-1:0] out_x,
	output logic [psdf_pkg::CoordW-1:0] out_y,
	output logic [psdf_pkg::CoordW-1:0] out_z
);
	import psdf_pkg::*;

`include "assert_macros.svh"

	psdf_cmd_t  cmd;
	psdf_stat_t stat;

	// sequencing of request intake, table scan and result hand-off
	psdf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// table, compare and result register
	psdf_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_type (req_type),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.out_x    (out_x),
		.out_y    (out_y),
		.out_z    (out_z)
	);

	// no table read while a new request can be taken
	`PSDF_ASSERT(a_no_read_when_idle, !(cmd.rd_en && in_ready), "table read while idle")
	// a result only moves into the output register when that register is free
	`PSDF_ASSERT(a_emit_free, !cmd.emit || stat.out_free, "result overwrites pending output")
	// one request at a time: intake closes right after a request is taken
	`PSDF_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken")
	// a scan never starts on an empty table
	`PSDF_ASSERT_NEXT(a_scan_nonempty, cmd.rd_en && stat.table_empty, 1'b0, "scan of empty table")

endmodule
